// ----- rtl/ook_pkg.sv -----
// ----------------------------------------------------------------------------
// ook_pkg
// Shared types, constants and the quarter-wave sine generator of the
// OOK envelope demodulator.
// ----------------------------------------------------------------------------
package ook_pkg;

    localparam int SAMPLE_WIDTH_DEF     = 16;
    localparam int SINE_TABLE_DEPTH_DEF = 1024;
    localparam int MAX_DECIMATION_DEF   = 4096;

    localparam int FIELD_W    = 16;
    localparam int PHASE_W    = 32;
    localparam int SUM_W      = 32;
    localparam int DEC_W      = 13;
    localparam int ENV_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int TAB_W      = 16;

    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECIMATION = 2'd1;

    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    typedef struct packed {
        logic signed [SUM_W-1:0] re;
        logic signed [SUM_W-1:0] im;
        logic [DEC_W-1:0]        dec;
    } win_t;

    // sin(x), x in Q30 radians over the first quadrant, result Q15
    function automatic int quad_sine(longint x);
        longint x2;
        longint term;
        longint acc;
        x2   = (x * x) >>> 30;
        term = x;
        acc  = x;
        term = ((term * x2) >>> 30) / 6;   acc = acc - term;
        term = ((term * x2) >>> 30) / 20;  acc = acc + term;
        term = ((term * x2) >>> 30) / 42;  acc = acc - term;
        term = ((term * x2) >>> 30) / 72;  acc = acc + term;
        term = ((term * x2) >>> 30) / 110; acc = acc - term;
        term = ((term * x2) >>> 30) / 156; acc = acc + term;
        if (acc < 0)
        begin
            acc = 0;
        end
        acc = (acc + 16384) >>> 15;
        if (acc > 32767)
        begin
            acc = 32767;
        end
        return int'(acc);
    endfunction

endpackage

// ----- rtl/ook_sine_rom.sv -----
// ----------------------------------------------------------------------------
// ook_sine_rom
// Quarter-wave cos/sin table with registered outputs.
// ----------------------------------------------------------------------------
module ook_sine_rom
    import ook_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF
)
(
    input  logic                              clk,
    input  logic                              en,
    input  logic [$clog2(SINE_TABLE_DEPTH)-1:0] idx,
    output logic signed [TAB_W-1:0]           cos_q15,
    output logic signed [TAB_W-1:0]           sin_q15
);

    localparam int AW  = $clog2(SINE_TABLE_DEPTH);
    localparam int QAW = AW - 2;
    localparam int QN  = SINE_TABLE_DEPTH / 4;

    typedef logic [TAB_W-1:0] qtab_t [0:QN];

    function automatic qtab_t build_qtab();
        qtab_t  t;
        longint x;
        for (int j = 0; j <= QN; j++)
        begin
            x    = (longint'(4 * j) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
            t[j] = TAB_W'(quad_sine(x));
        end
        return t;
    endfunction

    localparam qtab_t QTAB = build_qtab();

    logic [1:0]     quad_s;
    logic [1:0]     quad_c;
    logic [QAW-1:0] low;
    logic [QAW:0]   j_s;
    logic [QAW:0]   j_c;
    logic signed [TAB_W-1:0] v_s;
    logic signed [TAB_W-1:0] v_c;
    logic signed [TAB_W-1:0] cos_reg;
    logic signed [TAB_W-1:0] sin_reg;

    assign quad_s = idx[AW-1:AW-2];
    assign quad_c = quad_s + 2'd1;
    assign low    = idx[QAW-1:0];
    assign j_s    = quad_s[0] ? ((QAW+1)'(QN) - {1'b0, low}) : {1'b0, low};
    assign j_c    = quad_c[0] ? ((QAW+1)'(QN) - {1'b0, low}) : {1'b0, low};

    always_comb
    begin
        v_s = signed'(QTAB[j_s]);
        v_c = signed'(QTAB[j_c]);
        if (quad_s[1])
        begin
            v_s = -v_s;
        end
        if (quad_c[1])
        begin
            v_c = -v_c;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg <= v_c;
            sin_reg <= v_s;
        end
    end

    assign cos_q15 = cos_reg;
    assign sin_q15 = sin_reg;

endmodule

// ----- rtl/ook_front.sv -----
// ----------------------------------------------------------------------------
// ook_front
// Sample intake: NCO, mixer and integrate-and-dump; closed windows go to
// the window queue.
// ----------------------------------------------------------------------------
module ook_front
    import ook_pkg::*;
#(
    parameter int SAMPLE_WIDTH     = SAMPLE_WIDTH_DEF,
    parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
    parameter int MAX_DECIMATION   = MAX_DECIMATION_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [FIELD_W-1:0] i_sample,
    input  logic [FIELD_W-1:0] q_sample,
    input  logic               burst_last,
    input  logic [PHASE_W-1:0] phase_step,
    input  logic [DEC_W-1:0]   decimation,
    output logic               win_push,
    output win_t               win_data,
    input  logic               win_full
);

    localparam int AW = $clog2(SINE_TABLE_DEPTH);
    localparam int PW = SAMPLE_WIDTH + TAB_W;
    localparam int CW = (MAX_DECIMATION > 1) ? $clog2(MAX_DECIMATION) : 1;

    logic               adv;
    logic               accept;
    logic               emit;
    logic [PHASE_W-1:0] phase_reg, phase_next;

    logic                           v1_reg, last1_reg;
    logic signed [SAMPLE_WIDTH-1:0] i1_reg, q1_reg;
    logic signed [TAB_W-1:0]        c1, s1;

    logic                 v2_reg, last2_reg;
    logic signed [PW-1:0] p_ic_reg, p_qs_reg, p_is_reg, p_qc_reg;

    logic signed [SUM_W-1:0] sum_re_reg, sum_im_reg, sum_re_next, sum_im_next;
    logic [CW-1:0]           cnt_reg, cnt_next;

    logic signed [PW:0]    mix_re, mix_im;
    logic signed [PW:0]    rnd_re_full, rnd_im_full;
    logic signed [PW-15:0] rnd_re, rnd_im;
    logic [DEC_W-1:0]      d_eff;
    logic [DEC_W-1:0]      cnt_inc;

    assign emit   = v2_reg && (cnt_inc >= d_eff);
    assign adv    = !(emit && win_full);
    assign full   = !adv;
    assign accept = push && adv;

    assign phase_next = burst_last ? '0 : phase_reg + phase_step;

    ook_sine_rom #(
        .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
    ) u_rom (
        .clk     (clk),
        .en      (adv),
        .idx     (phase_reg[PHASE_W-1 -: AW]),
        .cos_q15 (c1),
        .sin_q15 (s1)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            cnt_reg   <= '0;
        end
        else if (adv)
        begin
            if (accept)
            begin
                phase_reg <= phase_next;
            end
            v1_reg <= accept;
            v2_reg <= v1_reg;
            if (v2_reg)
            begin
                cnt_reg <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            i1_reg    <= i_sample[SAMPLE_WIDTH-1:0];
            q1_reg    <= q_sample[SAMPLE_WIDTH-1:0];
            last1_reg <= burst_last;
            p_ic_reg  <= i1_reg * c1;
            p_qs_reg  <= q1_reg * s1;
            p_is_reg  <= i1_reg * s1;
            p_qc_reg  <= q1_reg * c1;
            last2_reg <= last1_reg;
        end
    end

    // sums are control state: they start every window from zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_re_reg <= '0;
            sum_im_reg <= '0;
        end
        else if (adv && v2_reg)
        begin
            sum_re_reg <= (emit || last2_reg) ? '0 : sum_re_next;
            sum_im_reg <= (emit || last2_reg) ? '0 : sum_im_next;
        end
    end

    always_comb
    begin
        mix_re      = (PW+1)'(p_ic_reg) - (PW+1)'(p_qs_reg);
        mix_im      = (PW+1)'(p_is_reg) + (PW+1)'(p_qc_reg);
        rnd_re_full = mix_re + (PW+1)'(16384);
        rnd_im_full = mix_im + (PW+1)'(16384);
        rnd_re      = rnd_re_full[PW:15];
        rnd_im      = rnd_im_full[PW:15];
        sum_re_next = sum_re_reg + SUM_W'(rnd_re);
        sum_im_next = sum_im_reg + SUM_W'(rnd_im);
    end

    always_comb
    begin
        priority if (decimation == '0)
        begin
            d_eff = DEC_W'(1);
        end
        else if (decimation > DEC_W'(MAX_DECIMATION))
        begin
            d_eff = DEC_W'(MAX_DECIMATION);
        end
        else
        begin
            d_eff = decimation;
        end
    end

    assign cnt_inc  = DEC_W'(cnt_reg) + DEC_W'(1);
    assign cnt_next = (emit || last2_reg) ? '0 : cnt_inc[CW-1:0];

    assign win_push     = emit && !win_full;
    assign win_data.re  = sum_re_next;
    assign win_data.im  = sum_im_next;
    assign win_data.dec = d_eff;

endmodule

// ----- rtl/ook_fifo.sv -----
// ----------------------------------------------------------------------------
// ook_fifo
// Small register queue between the sample front end and the envelope unit.
// ----------------------------------------------------------------------------
module ook_fifo
    import ook_pkg::*;
#(
    parameter int WIDTH = $bits(win_t),
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wptr_reg, rptr_reg;
    logic [AW:0]      cnt_reg;

    assign full  = (cnt_reg == (AW+1)'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign rdata = mem[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= (wptr_reg == AW'(DEPTH-1)) ? '0 : wptr_reg + AW'(1);
            end
            if (pop)
            begin
                rptr_reg <= (rptr_reg == AW'(DEPTH-1)) ? '0 : rptr_reg + AW'(1);
            end
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

endmodule

// ----- rtl/ook_back.sv -----
// ----------------------------------------------------------------------------
// ook_back
// Envelope unit: squares, bit-serial square root, serial divide by the
// window length, saturation and the output register.
// ----------------------------------------------------------------------------
module ook_back
    import ook_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             win_valid,
    input  win_t             win_data,
    output logic             win_pop,
    output logic             empty,
    input  logic             pop,
    output logic [ENV_W-1:0] envelope
);

    localparam int ROOT_STEPS = 32;
    localparam int DIV_STEPS  = SUM_W + 1;
    localparam int STEP_W     = 6;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SQUARE = 6'b000010,
        ST_SUM    = 6'b000100,
        ST_ROOT   = 6'b001000,
        ST_DIV    = 6'b010000,
        ST_HOLD   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [STEP_W-1:0]  step_reg, step_next;
    logic [SUM_W-1:0]   ar_reg, ai_reg;
    logic [DEC_W-1:0]   dec_reg;
    logic [63:0]        sqa_reg, sqb_reg;
    logic [63:0]        rad_reg, rad_next;
    logic [33:0]        rem_reg, rem_next;
    logic [31:0]        root_reg, root_next;
    logic [DIV_STEPS-1:0] num_reg, num_next;
    logic [DEC_W:0]     drem_reg, drem_next;
    logic [DIV_STEPS-1:0] quo_reg, quo_next;
    logic               out_valid_reg;
    logic [ENV_W-1:0]   env_reg;

    logic [33:0]  rem_sh, trial;
    logic [DEC_W:0] drem_sh;
    logic         load_out;

    assign rem_sh  = {rem_reg[31:0], rad_reg[63:62]};
    assign trial   = {root_reg, 2'b01};
    assign drem_sh = {drem_reg[DEC_W-1:0], num_reg[DIV_STEPS-1]};

    assign win_pop  = (state_reg == ST_IDLE) && win_valid;
    assign load_out = (state_reg == ST_HOLD) && (!out_valid_reg || pop);
    assign empty    = !out_valid_reg;
    assign envelope = env_reg;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        rad_next   = rad_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        num_next   = num_reg;
        drem_next  = drem_reg;
        quo_next   = quo_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (win_valid)
                begin
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                rad_next   = sqa_reg + sqb_reg;
                rem_next   = '0;
                root_next  = '0;
                step_next  = '0;
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                rad_next = {rad_reg[61:0], 2'b00};
                if (rem_sh >= trial)
                begin
                    rem_next  = rem_sh - trial;
                    root_next = {root_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh;
                    root_next = {root_reg[30:0], 1'b0};
                end
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(ROOT_STEPS-1))
                begin
                    step_next  = '0;
                    state_next = ST_DIV;
                    num_next   = DIV_STEPS'(root_next) + DIV_STEPS'(dec_reg >> 1);
                    drem_next  = '0;
                    quo_next   = '0;
                end
            end
            ST_DIV:
            begin
                num_next = {num_reg[DIV_STEPS-2:0], 1'b0};
                if (drem_sh >= {1'b0, dec_reg})
                begin
                    drem_next = drem_sh - {1'b0, dec_reg};
                    quo_next  = {quo_reg[DIV_STEPS-2:0], 1'b1};
                end
                else
                begin
                    drem_next = drem_sh;
                    quo_next  = {quo_reg[DIV_STEPS-2:0], 1'b0};
                end
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_STEPS-1))
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (win_pop)
        begin
            ar_reg  <= win_data.re[SUM_W-1] ? SUM_W'(-win_data.re) : SUM_W'(win_data.re);
            ai_reg  <= win_data.im[SUM_W-1] ? SUM_W'(-win_data.im) : SUM_W'(win_data.im);
            dec_reg <= win_data.dec;
        end
        if (state_reg == ST_SQUARE)
        begin
            sqa_reg <= 64'(ar_reg) * 64'(ar_reg);
            sqb_reg <= 64'(ai_reg) * 64'(ai_reg);
        end
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        num_reg  <= num_next;
        drem_reg <= drem_next;
        quo_reg  <= quo_next;
        if (load_out)
        begin
            env_reg <= (quo_reg > DIV_STEPS'(16'hFFFF)) ? 16'hFFFF : quo_reg[ENV_W-1:0];
        end
    end

endmodule

// ----- rtl/ook_envelope_demodulator_top.sv -----
// ----------------------------------------------------------------------------
// ook_envelope_demodulator_top
// OOK envelope demodulator: NCO downconversion, integrate-and-dump and
// window magnitude.
// ----------------------------------------------------------------------------
// Input words (i_sample, q_sample, burst_last) enter on push while full is
// low, one per cycle. Results leave as a queue: envelope is valid while
// empty is low and is taken with pop.
// Samples pass a three-stage front end (table, multiply, accumulate); each
// window closing is queued, then the envelope unit takes one window at a
// time: queue pop, squares, sum, 32 root steps, 33 divide steps and load.
// Intake runs at one sample per cycle while full is low; short windows can
// outpace the envelope unit, fill the queue and raise full.
// When the receiver stalls, the output word holds, one finished word waits
// in the envelope unit, two windows queue up, then full rises and intake
// stops until the queue drains.
// Reset clears phase, sums, window count, queue and output valid; phase_step
// resets to 0 and decimation to 1. Write config only while idle.
// ----------------------------------------------------------------------------
module ook_envelope_demodulator_top
    import ook_pkg::*;
#(
    parameter int SAMPLE_WIDTH     = SAMPLE_WIDTH_DEF,
    parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
    parameter int MAX_DECIMATION   = MAX_DECIMATION_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [FIELD_W-1:0]    i_sample,
    input  logic [FIELD_W-1:0]    q_sample,
    input  logic                  burst_last,
    output logic                  empty,
    input  logic                  pop,
    output logic [ENV_W-1:0]      envelope,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [PHASE_W-1:0] phase_step_reg;
    logic [DEC_W-1:0]   decimation_reg;

    logic win_push, win_full, win_empty, win_pop;
    win_t win_wdata, win_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg <= '0;
            decimation_reg <= DEC_W'(1);
        end
        else if (cfg_we)
        begin
            if (cfg_idx == REG_PHASE_STEP)
            begin
                phase_step_reg <= cfg_data[PHASE_W-1:0];
            end
            if (cfg_idx == REG_DECIMATION)
            begin
                decimation_reg <= cfg_data[DEC_W-1:0];
            end
        end
    end

    ook_front #(
        .SAMPLE_WIDTH     (SAMPLE_WIDTH),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .MAX_DECIMATION   (MAX_DECIMATION)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .i_sample   (i_sample),
        .q_sample   (q_sample),
        .burst_last (burst_last),
        .phase_step (phase_step_reg),
        .decimation (decimation_reg),
        .win_push   (win_push),
        .win_data   (win_wdata),
        .win_full   (win_full)
    );

    ook_fifo #(
        .WIDTH ($bits(win_t)),
        .DEPTH (2)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (win_push),
        .wdata (win_wdata),
        .full  (win_full),
        .pop   (win_pop),
        .rdata (win_rdata),
        .empty (win_empty)
    );

    ook_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .win_valid (!win_empty),
        .win_data  (win_rdata),
        .win_pop   (win_pop),
        .empty     (empty),
        .pop       (pop),
        .envelope  (envelope)
    );

endmodule

// ----- rtl/ook_checker.sv -----
// ----------------------------------------------------------------------------
// ook_checker
// Port-level checks of the OOK envelope demodulator.
// ----------------------------------------------------------------------------
module ook_checker
    import ook_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  push,
    input logic                  full,
    input logic [FIELD_W-1:0]    i_sample,
    input logic [FIELD_W-1:0]    q_sample,
    input logic                  burst_last,
    input logic                  empty,
    input logic                  pop,
    input logic [ENV_W-1:0]      envelope,
    input logic                  cfg_we,
    input logic [CFG_IDX_W-1:0]  cfg_idx,
    input logic [CFG_DATA_W-1:0] cfg_data
);

    a_reset_clear: assert property (@(posedge clk) !rst_n |-> empty && !full)
        else $error("queues not clear in reset");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(envelope))
        else $error("stalled envelope word changed");

    a_no_early_full: assert property (@(posedge clk)
        $rose(rst_n) |-> !full ##1 !full ##1 !full)
        else $error("full raised before any window could queue");

endmodule

bind ook_envelope_demodulator_top ook_checker u_ook_checker (.*);

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for ook_envelope_demodulator_top. A queue-fed driver
// pushes sample words with random gaps while a model of the NCO mixer
// and integrate-and-dump predicts each envelope word. A monitor pops with
// random stalls and compares every envelope against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
    import ook_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TAB_DEPTH = 1024;
    localparam int DEC_MAX = 4096;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 150;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd2;

    typedef struct packed {
        logic [FIELD_W-1:0] i_val;
        logic [FIELD_W-1:0] q_val;
        logic               last;
    } sample_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    logic [FIELD_W-1:0]    i_sample = '0;
    logic [FIELD_W-1:0]    q_sample = '0;
    logic                  burst_last = 1'b0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [ENV_W-1:0]      envelope;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    sample_t          sample_q[$];
    logic [ENV_W-1:0] envelope_q[$];
    sample_t          cur_word;

    longint cos_q15[TAB_DEPTH];
    longint sin_q15[TAB_DEPTH];

    logic [31:0]      nco_step = '0;
    logic [DEC_W-1:0] dec_reg = 1;
    logic [31:0]      nco_acc = '0;
    longint           acc_re = 0;
    longint           acc_im = 0;
    int               win_cnt = 0;

    int  errors = 0;
    int  idle_cycles = 0;
    int  push_gap = 0;
    int  pop_gap = 0;
    bit  steady = 0;

    always #4 clk = ~clk;

    ook_envelope_demodulator_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .i_sample   (i_sample),
        .q_sample   (q_sample),
        .burst_last (burst_last),
        .empty      (empty),
        .pop        (pop),
        .envelope   (envelope),
        .cfg_we     (cfg_we),
        .cfg_idx    (cfg_idx),
        .cfg_data   (cfg_data)
    );

    // sine of u quarter-steps (4*TAB_DEPTH per turn), Q15
    function automatic longint osc_sine(int u);
        int     quad;
        int     rem;
        int     arg;
        longint x;
        longint x2;
        longint term;
        longint acc;
        quad = u / TAB_DEPTH;
        rem  = u - quad * TAB_DEPTH;
        arg  = (quad % 2 == 1) ? TAB_DEPTH - rem : rem;
        x    = longint'(arg) * HALF_PI_Q30 / TAB_DEPTH;
        x2   = (x * x) >>> 30;
        term = x;
        acc  = x;
        for (int n = 1; n <= 6; n++)
        begin
            term = ((term * x2) >>> 30) / ((2 * n) * (2 * n + 1));
            acc  = (n % 2 == 1) ? acc - term : acc + term;
        end
        if (acc < 0)
        begin
            acc = 0;
        end
        acc = (acc + 16384) >>> 15;
        if (acc > 32767)
        begin
            acc = 32767;
        end
        return (quad >= 2) ? -acc : acc;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b   = 64'd1 << 62;
        while (b > v)
        begin
            b = b >> 2;
        end
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end
            else
            begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic void mix_and_dump(sample_t w);
        longint          iv;
        longint          qv;
        longint          c;
        longint          s;
        longint          d;
        longint unsigned ar;
        longint unsigned ai;
        longint unsigned mag;
        longint unsigned env;
        iv = longint'($signed(w.i_val));
        qv = longint'($signed(w.q_val));
        c  = cos_q15[nco_acc[31:22]];
        s  = sin_q15[nco_acc[31:22]];
        acc_re  = acc_re + ((iv * c - qv * s + 16384) >>> 15);
        acc_im  = acc_im + ((iv * s + qv * c + 16384) >>> 15);
        nco_acc = nco_acc + nco_step;
        d = (dec_reg == 0) ? 1 : (dec_reg > DEC_MAX) ? DEC_MAX : dec_reg;
        win_cnt++;
        if (win_cnt >= d)
        begin
            ar  = (acc_re < 0) ? -acc_re : acc_re;
            ai  = (acc_im < 0) ? -acc_im : acc_im;
            mag = int_sqrt(ar * ar + ai * ai);
            env = (mag + d / 2) / d;
            envelope_q.push_back((env > 65535) ? 16'hFFFF : env[15:0]);
            acc_re  = 0;
            acc_im  = 0;
            win_cnt = 0;
        end
        if (w.last)
        begin
            nco_acc = '0;
            acc_re  = 0;
            acc_im  = 0;
            win_cnt = 0;
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (steady || r < 60)
        begin
            return 0;
        end
        return (r < 95) ? $urandom_range(3, 1) : $urandom_range(40, 10);
    endfunction

    function automatic logic [FIELD_W-1:0] pick_value();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return FIELD_W'($urandom());
        endcase
    endfunction

    function automatic void add_word(logic [FIELD_W-1:0] iv, logic [FIELD_W-1:0] qv,
                                     logic last);
        sample_t w;
        w.i_val = iv;
        w.q_val = qv;
        w.last  = last;
        sample_q.push_back(w);
    endfunction

    function automatic void add_random(int n, int last_odds);
        for (int k = 0; k < n; k++)
        begin
            add_word(pick_value(), pick_value(), ($urandom_range(last_odds - 1) == 0));
        end
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (push && !full)
        begin
            mix_and_dump(cur_word);
        end
        if (!(push && full))
        begin
            if (push_gap > 0)
            begin
                push_gap--;
                push <= 1'b0;
            end
            else if (rst_n && sample_q.size() > 0)
            begin
                cur_word = sample_q.pop_front();
                push       <= 1'b1;
                i_sample   <= cur_word.i_val;
                q_sample   <= cur_word.q_val;
                burst_last <= cur_word.last;
                push_gap = pick_gap();
            end
            else
            begin
                push <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (pop && !empty)
        begin
            if (envelope_q.size() == 0)
            begin
                $display("%0t: unexpected envelope word, expected none, actual %0d",
                         $realtime, envelope);
                errors++;
            end
            else if (envelope !== envelope_q[0])
            begin
                $display("%0t: envelope mismatch, expected %0d, actual %0d",
                         $realtime, envelope_q[0], envelope);
                errors++;
                void'(envelope_q.pop_front());
            end
            else
            begin
                void'(envelope_q.pop_front());
            end
        end
        if ((push && !full) || (pop && !empty))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
        if (pop_gap > 0)
        begin
            pop_gap--;
            pop <= 1'b0;
        end
        else
        begin
            pop <= rst_n;
            pop_gap = pick_gap();
        end
    end

    task automatic wait_idle();
        do
        begin
            @(posedge clk);
        end
        while (sample_q.size() > 0 || push || envelope_q.size() > 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        if (idx == REG_PHASE_STEP)
        begin
            nco_step = data;
        end
        else if (idx == REG_DECIMATION)
        begin
            dec_reg = data[DEC_W-1:0];
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(logic [31:0] step, logic [DEC_W-1:0] dec, int n, int odds);
        wait_idle();
        write_reg(REG_PHASE_STEP, step);
        write_reg(REG_DECIMATION, {19'd0, dec});
        steady = ($urandom_range(3) == 0);
        add_random(n, odds);
    endtask

    initial
    begin
        for (int k = 0; k < TAB_DEPTH; k++)
        begin
            sin_q15[k] = osc_sine(4 * k);
            cos_q15[k] = osc_sine((4 * k + TAB_DEPTH) % (4 * TAB_DEPTH));
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        add_word(16'h7FFF, 16'h7FFF, 1'b0);
        add_word(16'h8000, 16'h8000, 1'b0);
        add_word(16'h7FFF, 16'h8000, 1'b0);
        add_word(16'h8000, 16'h7FFF, 1'b0);
        add_word(16'h0000, 16'h0000, 1'b0);
        add_word(16'hFFFF, 16'h0001, 1'b1);

        wait_idle();
        write_reg(REG_PHASE_STEP, 32'h4000_0000);
        write_reg(REG_DECIMATION, 32'd3);
        write_reg(REG_SPARE, 32'hFFFF_FFFF);
        add_word(16'h7FFF, 16'h0000, 1'b0);
        add_word(16'h7FFF, 16'h0000, 1'b0);
        add_word(16'h7FFF, 16'h0000, 1'b1);
        add_word(16'h8000, 16'h7FFF, 1'b0);
        add_word(16'h8000, 16'h7FFF, 1'b1);
        add_word(16'h1234, 16'hEDCB, 1'b0);
        add_word(16'h7FFF, 16'h7FFF, 1'b0);
        add_word(16'h8000, 16'h8000, 1'b0);
        add_word(16'h0001, 16'hFFFF, 1'b0);

        run_phase(32'h8000_0000, 13'd0, 120, 40);
        run_phase($urandom(), 13'd1, 150, 50);
        run_phase(32'h7FFF_FFFF, 13'd2, 120, 30);
        run_phase($urandom_range(1 << 22), 13'd17, 150, 200);
        run_phase($urandom(), 13'd100, 150, 1000);
        sample_q.delete();
        add_random(50, 100000);
        run_phase(32'hFFFF_FF00, 13'd2, 80, 40);
        run_phase($urandom(), 13'd8191, 200, 1000000);
        run_phase($urandom(), 13'd300, 250, 1000000);
        run_phase(~$urandom_range(1 << 24), 13'd5, 100, 60);

        wait_idle();
        if (errors == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
